[rtl/mlfe_pkg.sv]
// shared types and constants of the motor link frame engine
package mlfe_pkg;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] VERD_OK      = 2'd0;
  localparam logic [1:0] VERD_OPCODE  = 2'd1;
  localparam logic [1:0] VERD_CSUM    = 2'd2;
  localparam logic [1:0] VERD_TIMEOUT = 2'd3;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] OP_LVC     = 8'h60;
  localparam logic [7:0] OP_STATUS  = 8'h40;
  localparam logic [7:0] OP_CURRENT = 8'h41;
  localparam logic [7:0] OP_VOLTAGE = 8'h42;

  localparam logic [2:0] LEN_SHORT = 3'd4;
  localparam logic [2:0] LEN_LONG  = 3'd5;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // scale factors and reciprocals, exact for the full product range
  localparam logic [6:0]  MUL_CURRENT = 7'd100;
  localparam logic [6:0]  MUL_VOLTAGE = 7'd10;
  localparam logic [23:0] RCP_CURRENT = 24'd15561476;
  localparam logic [23:0] RCP_VOLTAGE = 24'd1198373;

  typedef enum logic [1:0] {
    SC_NONE,
    SC_CURRENT,
    SC_VOLTAGE
  } scale_t;

  typedef struct packed {
    logic        is_send;
    logic [7:0]  opcode;
    logic [15:0] data;
    logic [1:0]  verdict;
    scale_t      scale;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TX,
    BK_MUL,
    BK_DIV,
    BK_VERD
  } back_state_t;

endpackage

[rtl/motor_link_frame_engine.sv]
// motor link frame engine top level
//
//  channel  direction  handshake             word
//  in_      input      in_valid/in_ready     cmd, opcode, payload, rx_byte
//  out_     output     out_valid/out_ready   kind, tx_byte, tx_last, verdict, values
//  cfg_     input      cfg_we                16-bit timeout in ticks
//
// an input word is taken every cycle while the two-entry job queue has room
// a send drains as 3 to 5 output words, one per cycle unless the output stalls, from the back end
// a verdict passes through scale multiply, then reciprocal multiply, then output
// synchronous active-low reset; no clearing pass
// output stalls back up through the queue to in_ready
module motor_link_frame_engine import mlfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_opcode,
  input  logic [15:0] in_payload,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic [1:0]  out_verdict,
  output logic [15:0] out_resp_value,
  output logic [15:0] out_scaled_value
);

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  job_t push_job;
  job_t pop_job;

  assign in_ready = !q_full;

  mlfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (in_valid && in_ready),
    .cmd       (in_cmd),
    .opcode    (in_opcode),
    .payload   (in_payload),
    .rx_byte   (in_rx_byte),
    .push      (push),
    .job       (push_job)
  );

  mlfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  mlfe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (pop_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tx_byte      (out_tx_byte),
    .out_tx_last      (out_tx_last),
    .out_verdict      (out_verdict),
    .out_resp_value   (out_resp_value),
    .out_scaled_value (out_scaled_value)
  );

endmodule

[rtl/mlfe_front.sv]
// front end: accepts words, tracks the response frame and issues jobs
module mlfe_front import mlfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        acc,
  input  logic [1:0]  cmd,
  input  logic [7:0]  opcode,
  input  logic [15:0] payload,
  input  logic [7:0]  rx_byte,
  output logic        push,
  output job_t        job
);

  logic [15:0] timeout_r;
  logic [7:0]  exp_op_r, exp_op_nxt;
  logic [2:0]  exp_len_r, exp_len_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        await_r, await_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  b1_r, b1_nxt;
  logic [7:0]  b2_r, b2_nxt;
  logic [7:0]  b3_r, b3_nxt;
  logic [15:0] tick_inc;

  always_comb begin
    exp_op_nxt  = exp_op_r;
    exp_len_nxt = exp_len_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    await_nxt   = await_r;
    tick_nxt    = tick_r;
    b1_nxt      = b1_r;
    b2_nxt      = b2_r;
    b3_nxt      = b3_r;
    push        = 1'b0;
    job         = '0;
    tick_inc    = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;
    if (acc) begin
      case (cmd)
        CMD_SEND: begin
          push        = 1'b1;
          job.is_send = 1'b1;
          job.opcode  = opcode;
          job.data    = payload;
          exp_op_nxt  = opcode;
          exp_len_nxt = (opcode == OP_LVC || opcode == OP_STATUS || opcode == OP_VOLTAGE)
                        ? LEN_LONG : LEN_SHORT;
          cnt_nxt     = 3'd0;
          sum_nxt     = 8'd0;
          tick_nxt    = 16'd0;
          await_nxt   = 1'b1;
        end
        CMD_BYTE: begin
          if (await_r && cnt_r < exp_len_r) begin
            if (cnt_r == 3'd1) b1_nxt = rx_byte;
            if (cnt_r == 3'd2) b2_nxt = rx_byte;
            if (cnt_r == 3'd3) b3_nxt = rx_byte;
            if (cnt_r >= 3'd1 && ({1'b0, cnt_r} + 4'd2) <= {1'b0, exp_len_r})
              sum_nxt = sum_r + rx_byte;
            cnt_nxt = cnt_r + 3'd1;
            if (cnt_nxt == exp_len_r) begin
              await_nxt  = 1'b0;
              push       = 1'b1;
              job.opcode = exp_op_r;
              if (b1_r != exp_op_r) begin
                job.verdict = VERD_OPCODE;
              end else if (rx_byte != sum_r) begin
                job.verdict = VERD_CSUM;
              end else begin
                job.verdict = VERD_OK;
                job.data    = (exp_len_r == LEN_LONG) ? {b2_r, b3_r} : {8'd0, b2_r};
                if (exp_op_r == OP_CURRENT) job.scale = SC_CURRENT;
                else if (exp_op_r == OP_VOLTAGE) job.scale = SC_VOLTAGE;
              end
            end
          end
        end
        CMD_TICK: begin
          if (await_r) begin
            tick_nxt = tick_inc;
            if (tick_inc >= timeout_r) begin
              await_nxt   = 1'b0;
              push        = 1'b1;
              job.opcode  = exp_op_r;
              job.verdict = VERD_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      exp_op_r  <= 8'd0;
      exp_len_r <= LEN_SHORT;
      cnt_r     <= 3'd0;
      sum_r     <= 8'd0;
      await_r   <= 1'b0;
      tick_r    <= 16'd0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      exp_op_r  <= exp_op_nxt;
      exp_len_r <= exp_len_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      await_r   <= await_nxt;
      tick_r    <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b1_r <= b1_nxt;
    b2_r <= b2_nxt;
    b3_r <= b3_nxt;
  end

endmodule

[rtl/mlfe_queue.sv]
// two-entry job queue between front and back
module mlfe_queue import mlfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  job_t       mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign pop_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/mlfe_back.sv]
// back end: serializes request frames and scales response verdicts
module mlfe_back import mlfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic [1:0]  out_verdict,
  output logic [15:0] out_resp_value,
  output logic [15:0] out_scaled_value
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [2:0]  idx_r;
  logic [22:0] prod_r;
  logic [15:0] quot_r;

  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  tx_byte_r;
  logic        tx_last_r;
  logic [1:0]  verdict_r;
  logic [15:0] resp_r;
  logic [15:0] scaled_r;

  logic        out_free;
  logic        emit_tx;
  logic        emit_vd;
  logic        done;
  logic [2:0]  ndata;
  logic        is_last;
  logic [7:0]  tx_byte;
  logic [7:0]  tx_sum;
  logic [6:0]  mul_k;
  logic [23:0] rcp;
  logic [46:0] full_prod;

  // frame byte selection
  always_comb begin
    if (job_r.opcode == OP_LVC) ndata = 3'd2;
    else if (job_r.opcode == OP_STATUS || job_r.opcode == OP_CURRENT ||
             job_r.opcode == OP_VOLTAGE) ndata = 3'd0;
    else ndata = 3'd1;
    case (ndata)
      3'd2:    tx_sum = job_r.opcode + job_r.data[15:8] + job_r.data[7:0];
      3'd1:    tx_sum = job_r.opcode + job_r.data[7:0];
      default: tx_sum = job_r.opcode;
    endcase
    is_last = (idx_r == ndata + 3'd2);
    case (idx_r)
      3'd0: tx_byte = START_BYTE;
      3'd1: tx_byte = job_r.opcode;
      3'd2: begin
        if (ndata == 3'd2) tx_byte = job_r.data[15:8];
        else if (ndata == 3'd1) tx_byte = job_r.data[7:0];
        else tx_byte = tx_sum;
      end
      3'd3: tx_byte = (ndata == 3'd2) ? job_r.data[7:0] : tx_sum;
      default: tx_byte = tx_sum;
    endcase
  end

  // scaling datapath
  always_comb begin
    mul_k     = (job_r.scale == SC_CURRENT) ? MUL_CURRENT : MUL_VOLTAGE;
    rcp       = (job_r.scale == SC_CURRENT) ? RCP_CURRENT : RCP_VOLTAGE;
    full_prod = {24'd0, prod_r} * {23'd0, rcp};
  end

  // outputs
  always_comb begin
    out_free = !out_valid_r || out_ready;
    emit_tx  = (state_r == BK_TX) && out_free;
    emit_vd  = (state_r == BK_VERD) && out_free;
    done     = (emit_tx && is_last) || emit_vd;
    pop      = q_valid && ((state_r == BK_IDLE) || done);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop) state_nxt = q_job.is_send ? BK_TX : BK_MUL;
      end
      BK_TX: begin
        if (emit_tx && is_last) begin
          if (pop) state_nxt = q_job.is_send ? BK_TX : BK_MUL;
          else state_nxt = BK_IDLE;
        end
      end
      BK_MUL:  state_nxt = BK_DIV;
      BK_DIV:  state_nxt = BK_VERD;
      BK_VERD: begin
        if (emit_vd) begin
          if (pop) state_nxt = q_job.is_send ? BK_TX : BK_MUL;
          else state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_tx || emit_vd) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
      idx_r <= 3'd0;
    end else if (emit_tx) begin
      idx_r <= idx_r + 3'd1;
    end
    if (state_r == BK_MUL) prod_r <= {7'd0, job_r.data} * {16'd0, mul_k};
    if (state_r == BK_DIV) begin
      case (job_r.scale)
        SC_CURRENT: quot_r <= full_prod[45:30];
        SC_VOLTAGE: quot_r <= full_prod[39:24];
        default:    quot_r <= job_r.data;
      endcase
    end
    if (emit_tx) begin
      kind_r    <= 1'b0;
      tx_byte_r <= tx_byte;
      tx_last_r <= is_last;
      verdict_r <= VERD_OK;
      resp_r    <= 16'd0;
      scaled_r  <= 16'd0;
    end else if (emit_vd) begin
      kind_r    <= 1'b1;
      tx_byte_r <= 8'd0;
      tx_last_r <= 1'b0;
      verdict_r <= job_r.verdict;
      resp_r    <= job_r.data;
      scaled_r  <= quot_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_tx_byte      = tx_byte_r;
  assign out_tx_last      = tx_last_r;
  assign out_verdict      = verdict_r;
  assign out_resp_value   = resp_r;
  assign out_scaled_value = scaled_r;

endmodule

[tb/motor_link_frame_engine_tb.sv]
// testbench for the motor link frame engine: request frames, response verdicts, timeouts
module motor_link_frame_engine_tb;
  import mlfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_WORDS = 28;

  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic [1:0] CHK_MODEL = 2'd0;
  localparam logic [1:0] CHK_NONE  = 2'd1;
  localparam logic [1:0] CHK_WORD  = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [1:0]  verdict;
    logic [15:0] resp_value;
    logic [15:0] scaled_value;
  } link_word_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  opcode;
    logic [15:0] payload;
    logic [7:0]  rx_byte;
    logic [1:0]  mode;
    link_word_t  word;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [7:0]  in_opcode;
  logic [15:0] in_payload;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [7:0]  out_tx_byte;
  logic        out_tx_last;
  logic [1:0]  out_verdict;
  logic [15:0] out_resp_value;
  logic [15:0] out_scaled_value;

  motor_link_frame_engine u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_opcode        (in_opcode),
    .in_payload       (in_payload),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tx_byte      (out_tx_byte),
    .out_tx_last      (out_tx_last),
    .out_verdict      (out_verdict),
    .out_resp_value   (out_resp_value),
    .out_scaled_value (out_scaled_value)
  );

  // predictor state
  logic [15:0] tmo_cfg = TIMEOUT_RESET;
  logic [7:0]  exp_op = 8'h00;
  logic [2:0]  exp_len = LEN_SHORT;
  int          rx_cnt = 0;
  logic [7:0]  rx_frame [0:7];
  logic [7:0]  rx_sum = 8'h00;
  logic        awaiting = 1'b0;
  logic [15:0] tick_cnt = 16'h0000;

  link_word_t  pred_buf [0:4];
  int          pred_n;
  link_word_t  expected_words [$];
  link_word_t  got_word;
  link_word_t  want_word;

  logic [1:0]  row_mode;
  link_word_t  row_word;
  stim_row_t   dir_rows [$];

  bit          no_gaps = 1'b0;
  bit          rx_hold = 1'b0;
  int          fail_cnt = 0;
  int          stall_cycles = 0;
  int          phase_items = 0;
  int          n_items = 0;
  int          n_sends = 0;
  int          n_checked = 0;
  int          n_cfg = 0;
  int          verd_cnt [0:3] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic put_tx(input logic [7:0] b, input logic last);
    pred_buf[pred_n] = '{kind: 1'b0, tx_byte: b, tx_last: last, verdict: VERD_OK,
                         resp_value: 16'h0, scaled_value: 16'h0};
    pred_n++;
  endtask

  task automatic put_verd(input logic [1:0] v, input logic [15:0] rv, input logic [15:0] sv);
    pred_buf[pred_n] = '{kind: 1'b1, tx_byte: 8'h00, tx_last: 1'b0, verdict: v,
                         resp_value: rv, scaled_value: sv};
    pred_n++;
    verd_cnt[v]++;
  endtask

  task automatic predict_link_words(input logic [1:0] cmd, input logic [7:0] op,
                                    input logic [15:0] pl, input logic [7:0] rx);
    logic [7:0]  sum;
    logic [31:0] v;
    logic [31:0] s;
    pred_n = 0;
    case (cmd)
      CMD_SEND: begin
        sum = op;
        put_tx(START_BYTE, 1'b0);
        put_tx(op, 1'b0);
        if (op == OP_LVC) begin
          put_tx(pl[15:8], 1'b0);
          put_tx(pl[7:0], 1'b0);
          sum = sum + pl[15:8] + pl[7:0];
        end else if (op != OP_STATUS && op != OP_CURRENT && op != OP_VOLTAGE) begin
          put_tx(pl[7:0], 1'b0);
          sum = sum + pl[7:0];
        end
        put_tx(sum, 1'b1);
        exp_op = op;
        exp_len = (op == OP_LVC || op == OP_STATUS || op == OP_VOLTAGE) ? LEN_LONG : LEN_SHORT;
        rx_cnt = 0;
        rx_sum = 8'h00;
        tick_cnt = 16'h0000;
        awaiting = 1'b1;
        n_sends++;
      end
      CMD_BYTE: begin
        if (awaiting && rx_cnt < exp_len) begin
          rx_frame[rx_cnt] = rx;
          if (rx_cnt >= 1 && rx_cnt + 2 <= exp_len) rx_sum = rx_sum + rx;
          rx_cnt++;
          if (rx_cnt == exp_len) begin
            awaiting = 1'b0;
            if (rx_frame[1] != exp_op) begin
              put_verd(VERD_OPCODE, 16'h0, 16'h0);
            end else if (rx_frame[exp_len - 1] != rx_sum) begin
              put_verd(VERD_CSUM, 16'h0, 16'h0);
            end else begin
              if (exp_len == LEN_LONG) v = {16'h0, rx_frame[2], rx_frame[3]};
              else v = {24'h0, rx_frame[2]};
              if (exp_op == OP_CURRENT) s = (v * 32'd100) / 32'd69;
              else if (exp_op == OP_VOLTAGE) s = (v * 32'd10) / 32'd14;
              else s = v;
              put_verd(VERD_OK, v[15:0], s[15:0]);
            end
          end
        end
      end
      CMD_TICK: begin
        if (awaiting) begin
          if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= tmo_cfg) begin
            awaiting = 1'b0;
            put_verd(VERD_TIMEOUT, 16'h0, 16'h0);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        tmo_cfg = cfg_wdata;
        n_cfg++;
      end
      if (out_valid && out_ready) begin
        got_word = '{kind: out_kind, tx_byte: out_tx_byte, tx_last: out_tx_last,
                     verdict: out_verdict, resp_value: out_resp_value,
                     scaled_value: out_scaled_value};
        if (expected_words.size() == 0) begin
          $error("output word with nothing expected: %0h", got_word);
          fail_cnt++;
        end else begin
          want_word = expected_words.pop_front();
          check_field("kind", want_word.kind, got_word.kind);
          check_field("tx_byte", want_word.tx_byte, got_word.tx_byte);
          check_field("tx_last", want_word.tx_last, got_word.tx_last);
          check_field("verdict", want_word.verdict, got_word.verdict);
          check_field("resp_value", want_word.resp_value, got_word.resp_value);
          check_field("scaled_value", want_word.scaled_value, got_word.scaled_value);
          n_checked++;
        end
      end
      if (in_valid && in_ready) begin
        predict_link_words(in_cmd, in_opcode, in_payload, in_rx_byte);
        n_items++;
        if (row_mode == CHK_MODEL) begin
          for (int i = 0; i < pred_n; i++) expected_words.push_back(pred_buf[i]);
        end else if (row_mode == CHK_WORD) begin
          expected_words.push_back(row_word);
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words pending",
                 stall_cycles, expected_words.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic drive_word(input logic [1:0] cmd, input logic [7:0] op, input logic [15:0] pl,
                            input logic [7:0] rx, input logic [1:0] mode, input link_word_t word);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_opcode  <= op;
    in_payload <= pl;
    in_rx_byte <= rx;
    row_mode   <= mode;
    row_word   <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drive_rand(input logic [1:0] cmd, input logic [7:0] op, input logic [7:0] rx);
    drive_word(cmd, op, 16'($urandom), rx, CHK_MODEL, '0);
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [7:0] op, input logic [15:0] pl,
                         input logic [7:0] rx, input logic [1:0] mode, input logic [1:0] verd,
                         input logic [15:0] rv, input logic [15:0] sv);
    dir_rows.push_back('{cmd: cmd, opcode: op, payload: pl, rx_byte: rx, mode: mode,
                         word: '{kind: 1'b1, tx_byte: 8'h00, tx_last: 1'b0, verdict: verd,
                                 resp_value: rv, scaled_value: sv}});
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_exchange();
    logic [7:0] op;
    logic [7:0] resp [0:4];
    logic [7:0] sum;
    int len;
    int style;
    int n_bytes;
    int n_ticks;
    if ($urandom_range(0, 9) == 0) drive_word(2'($urandom_range(1, 3)), 8'($urandom),
                                              16'($urandom), 8'($urandom), CHK_MODEL, '0);
    case ($urandom_range(0, 9))
      0, 1: op = OP_STATUS;
      2: op = OP_CURRENT;
      3: op = OP_VOLTAGE;
      4, 5: op = OP_LVC;
      default: op = 8'($urandom);
    endcase
    drive_rand(CMD_SEND, op, 8'($urandom));
    phase_items++;
    len = (op == OP_LVC || op == OP_STATUS || op == OP_VOLTAGE) ? 5 : 4;
    resp[0] = 8'($urandom);
    resp[1] = op;
    sum = op;
    for (int i = 2; i < len - 1; i++) begin
      resp[i] = 8'($urandom);
      sum = sum + resp[i];
    end
    resp[len - 1] = sum;
    style = $urandom_range(0, 9);
    if (style == 6) resp[1] = op ^ 8'($urandom_range(1, 255));
    if (style == 7) resp[len - 1] = sum ^ 8'($urandom_range(1, 255));
    n_bytes = (style >= 8) ? $urandom_range(0, len - 1) : len;
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        drive_rand(CMD_TICK, 8'($urandom), 8'($urandom));
        phase_items++;
      end
      drive_rand(CMD_BYTE, 8'($urandom), resp[i]);
      phase_items++;
    end
    if (style >= 8) begin
      n_ticks = (tmo_cfg <= 16'd8) ? int'(tmo_cfg) + 1 : $urandom_range(1, 3);
      repeat (n_ticks) begin
        drive_rand(CMD_TICK, 8'($urandom), 8'($urandom));
        phase_items++;
      end
      // bytes arriving after the ticks; the wait has ended only when the timeout is 8 or less
      if (style == 9) repeat ($urandom_range(1, 2))
        drive_rand(CMD_BYTE, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [15:0] tmo;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 16'h0000;
    in_valid   = 1'b0;
    in_cmd     = CMD_SEND;
    in_opcode  = 8'h00;
    in_payload = 16'h0000;
    in_rx_byte = 8'h00;
    row_mode   = CHK_MODEL;
    row_word   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle words right after reset produce nothing
    add_row(CMD_TICK, 8'hFF, 16'hFFFF, 8'hFF, CHK_NONE, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h40, CHK_NONE, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_NOP, 8'h40, 16'h1234, 8'hAA, CHK_NONE, VERD_OK, 16'h0, 16'h0);
    // status request, good long response
    add_row(CMD_SEND, OP_STATUS, 16'hFFFF, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h40, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h12, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h34, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h86, CHK_WORD, VERD_OK, 16'h1234, 16'h1234);
    // voltage at full scale
    add_row(CMD_SEND, OP_VOLTAGE, 16'h0000, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'hFF, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h42, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'hFF, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'hFF, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h40, CHK_WORD, VERD_OK, 16'hFFFF, 16'd46810);
    // back-to-back sends; each after the first abandons the pending response
    add_row(CMD_SEND, 8'h00, 16'hABCD, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_SEND, OP_LVC, 16'hFFFF, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_SEND, OP_CURRENT, 16'h5555, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    // opcode mismatch
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h40, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h01, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h41, CHK_WORD, VERD_OPCODE, 16'h0, 16'h0);
    // checksum mismatch
    add_row(CMD_SEND, 8'hFF, 16'h0000, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'hFF, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'hFF, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h00, CHK_MODEL, VERD_OK, 16'h0, 16'h0);
    add_row(CMD_BYTE, 8'h00, 16'h0000, 8'h00, CHK_WORD, VERD_CSUM, 16'h0, 16'h0);

    foreach (dir_rows[i])
      drive_word(dir_rows[i].cmd, dir_rows[i].opcode, dir_rows[i].payload,
                 dir_rows[i].rx_byte, dir_rows[i].mode, dir_rows[i].word);
    finish_phase();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: tmo = 16'd1;
        1: tmo = 16'd0;
        2: tmo = 16'hFFFF;
        3: tmo = 16'd3;
        4: tmo = TIMEOUT_RESET;
        default: tmo = 16'($urandom_range(2, 8));
      endcase
      write_timeout(tmo);
      no_gaps = (ph == 3) || ($urandom_range(0, 3) == 0);
      if (ph == 2) rx_hold = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_WORDS) random_exchange();
      finish_phase();
    end

    $display("covered %0d input words, %0d requests, %0d output words, %0d timeout writes",
             n_items, n_sends, n_checked, n_cfg);
    $display("verdicts: ok %0d, opcode %0d, checksum %0d, timeout %0d",
             verd_cnt[VERD_OK], verd_cnt[VERD_OPCODE], verd_cnt[VERD_CSUM],
             verd_cnt[VERD_TIMEOUT]);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
